>>> design/ssg_pkg.sv
`default_nettype none

package ssg_pkg;

  localparam int unsigned POS_W = 32;
  localparam int unsigned PER_W = 24;
  localparam int unsigned OFS_W = 16;
  localparam int unsigned CFG_W = 24;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [PER_W-1:0] TICKS_MAX = {PER_W{1'b1}};
  localparam logic [PER_W-1:0] RESET_PERIOD = PER_W'(1000);
  localparam logic [OFS_W-1:0] RESET_BACKOFF_STEPS = OFS_W'(400);
  localparam logic [PER_W-1:0] RESET_HOMING_PERIOD = PER_W'(1000);
  localparam logic [PER_W-1:0] RESET_SLOW_PERIOD = PER_W'(5000);

  typedef enum logic [2:0] {
    FUNC_TICK       = 3'd0,
    FUNC_SET_TARGET = 3'd1,
    FUNC_SET_PERIOD = 3'd2,
    FUNC_HOME       = 3'd3,
    FUNC_MOVE       = 3'd4
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BACKOFF_STEPS = 2'd0,
    CFG_HOMING_PERIOD = 2'd1,
    CFG_SLOW_PERIOD   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]              func;
    logic signed [31:0]      target_steps;
    logic [23:0]             step_period;
    logic                    home_switch;
  } in_item_t;

  typedef struct packed {
    logic                    step_pulse;
    logic                    direction;
    logic signed [31:0]      position;
    logic                    moving;
    logic                    homing;
  } out_item_t;

  typedef struct packed {
    logic [OFS_W-1:0] backoff_steps;
    logic [PER_W-1:0] homing_period;
    logic [PER_W-1:0] slow_homing_period;
  } cfg_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos;
    logic signed [POS_W-1:0] tgt;
    logic [PER_W-1:0]        ticks;
    logic [PER_W-1:0]        period;
    logic                    move_en;
    logic                    heading_up;
    logic                    dir;
    logic                    homing;
    logic                    backing_off;
    logic                    slow_phase;
  } state_t;

endpackage

`default_nettype wire

>>> design/ssg_step.sv
`default_nettype none

module ssg_step (
  input  wire ssg_pkg::state_t   st_i,
  input  wire ssg_pkg::cfg_t     cfg_i,
  input  wire ssg_pkg::in_item_t item_i,
  output ssg_pkg::state_t        st_o,
  output ssg_pkg::out_item_t     res_o
);
  import ssg_pkg::*;

  logic [PER_W-1:0]        ticks_inc;
  logic [PER_W-1:0]        ticks_mv;
  logic signed [POS_W-1:0] pos_mv;
  logic                    short_of;
  logic                    due1;
  logic                    due2;
  logic                    mv_step;
  logic                    pulse;

  always_comb begin
    ticks_inc = (st_i.ticks != TICKS_MAX) ? st_i.ticks + PER_W'(1) : st_i.ticks;
    short_of  = st_i.heading_up ? (st_i.pos < st_i.tgt) : (st_i.tgt < st_i.pos);
    due1      = ticks_inc >= st_i.period;
    mv_step   = st_i.move_en && due1 && short_of;
    if (mv_step) begin
      pos_mv = st_i.heading_up ? st_i.pos + POS_W'(1) : st_i.pos - POS_W'(1);
    end else begin
      pos_mv = st_i.pos;
    end
    ticks_mv = mv_step ? '0 : ticks_inc;
    due2     = mv_step ? (st_i.period == '0) : due1;
  end

  always_comb begin
    st_o  = st_i;
    pulse = 1'b0;
    unique case (item_i.func)
      FUNC_SET_TARGET: begin
        st_o.tgt        = POS_W'(item_i.target_steps);
        st_o.heading_up = st_i.pos < POS_W'(item_i.target_steps);
        st_o.dir        = st_i.pos < POS_W'(item_i.target_steps);
      end
      FUNC_SET_PERIOD: begin
        st_o.period = PER_W'(item_i.step_period);
      end
      FUNC_HOME: begin
        st_o.homing = 1'b1;
        st_o.period = cfg_i.homing_period;
        st_o.dir    = 1'b0;
      end
      FUNC_MOVE: begin
        st_o.move_en = 1'b1;
      end
      FUNC_TICK: begin
        st_o.ticks = ticks_mv;
        st_o.pos   = pos_mv;
        pulse      = mv_step;
        if (st_i.move_en && (pos_mv == st_i.tgt)) begin
          st_o.move_en = 1'b0;
        end
        if (st_i.homing) begin
          if (st_i.backing_off) begin
            if (!(pos_mv < st_i.tgt)) begin
              st_o.dir         = 1'b0;
              st_o.backing_off = 1'b0;
              st_o.period      = cfg_i.slow_homing_period;
            end else if (due2) begin
              st_o.pos   = pos_mv + POS_W'(1);
              st_o.ticks = '0;
              pulse      = 1'b1;
            end
          end else if (item_i.home_switch) begin
            if (due2) begin
              st_o.ticks = '0;
              pulse      = 1'b1;
            end
          end else if (st_i.slow_phase) begin
            st_o.homing     = 1'b0;
            st_o.slow_phase = 1'b0;
            st_o.pos        = '0;
          end else begin
            st_o.slow_phase  = 1'b1;
            st_o.backing_off = 1'b1;
            st_o.pos         = '0;
            st_o.tgt         = POS_W'(cfg_i.backoff_steps);
            st_o.dir         = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign res_o.step_pulse = pulse;
  assign res_o.direction  = st_o.dir;
  assign res_o.position   = 32'(st_o.pos);
  assign res_o.moving     = st_o.move_en;
  assign res_o.homing     = st_o.homing;

endmodule

`default_nettype wire

>>> design/stepper_step_generator_with_homing_unit.sv
// step/direction generator for one stepper axis with three-phase homing
// input channel (in_valid_i, in_ready_o, in_item_i): one item per timebase
//   tick or command; func selects tick, set target, set period, start homing
//   or enable move
// output channel (out_valid_o, out_ready_i, out_item_o): exactly one result
//   item per input item, in order: step pulse, direction, position, flags
// config channel (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i): back-off
//   distance, fast and slow homing periods; always ready, write only when idle
// path: an accepted item is captured in the input register, then processed and
//   loaded into the result register once that register is free or being taken,
//   and its result is offered from the result register until it is taken
// throughput: one item per cycle while results are taken, set by the
//   combinational axis update between the input register and the result register
// stall: while the result register holds an untaken item, the input register
//   can still take one more item; in_ready_o drops only when both are full
// reset: clears position, target, counter and flags but sets heading_up, loads
//   the default period and homing registers, and empties both pipeline registers
`default_nettype none

module stepper_step_generator_with_homing_unit (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire ssg_pkg::in_item_t         in_item_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output ssg_pkg::out_item_t             out_item_o,
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire [ssg_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire [ssg_pkg::CFG_W-1:0]       cfg_data_i
);
  import ssg_pkg::*;

  logic      s1_valid_q;
  in_item_t  s1_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  state_t    st_q;
  state_t    st_d;
  cfg_t      cfg_q;
  out_item_t res;
  logic      adv;
  logic      in_fire;
  logic      s1_fire;

  assign adv         = !out_valid_q || out_ready_i;
  assign in_ready_o  = !s1_valid_q || adv;
  assign in_fire     = in_valid_i && in_ready_o;
  assign s1_fire     = s1_valid_q && adv;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  ssg_step u_step (
    .st_i   (st_q),
    .cfg_i  (cfg_q),
    .item_i (s1_item_q),
    .st_o   (st_d),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_item_i;
    end
    if (s1_fire) begin
      out_item_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.pos         <= '0;
      st_q.tgt         <= '0;
      st_q.ticks       <= '0;
      st_q.period      <= RESET_PERIOD;
      st_q.move_en     <= 1'b0;
      st_q.heading_up  <= 1'b1;
      st_q.dir         <= 1'b0;
      st_q.homing      <= 1'b0;
      st_q.backing_off <= 1'b0;
      st_q.slow_phase  <= 1'b0;
    end else if (s1_fire) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.backoff_steps      <= RESET_BACKOFF_STEPS;
      cfg_q.homing_period      <= RESET_HOMING_PERIOD;
      cfg_q.slow_homing_period <= RESET_SLOW_PERIOD;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_BACKOFF_STEPS: cfg_q.backoff_steps      <= OFS_W'(cfg_data_i);
        CFG_HOMING_PERIOD: cfg_q.homing_period      <= PER_W'(cfg_data_i);
        CFG_SLOW_PERIOD:   cfg_q.slow_homing_period <= PER_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // homing sub-phases only exist inside an active sequence
  a_phase_in_homing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !st_q.homing |-> (!st_q.backing_off && !st_q.slow_phase))
    else $error("homing phase flag set outside homing");

  a_backoff_slow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.backing_off |-> st_q.slow_phase)
    else $error("back-off without slow phase pending");

  // every issued step restarts the tick counter
  a_pulse_clears_ticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && res.step_pulse) |-> (st_d.ticks == '0))
    else $error("step issued without counter clear");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty result register");

  a_pos_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(st_q.pos))
    else $error("position changed without an item");

endmodule

`default_nettype wire
